// ----- rtl/core/grma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grma_pkg
// Shared types and constants of the group request max aggregator.
// ----------------------------------------------------------------------------
package grma_pkg;

   localparam int DEF_NUM_GROUPS     = 8;
   localparam int DEF_NUM_REQUESTERS = 32;

   localparam int CMD_W  = 1;
   localparam int REQ_W  = 5;
   localparam int GRP_W  = 4;
   localparam int VOTE_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_SCAN,
      ST_SCAN_END,
      ST_RESP
   } state_type;

   // store port controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

endpackage

// ----- rtl/core/group_request_max_aggregator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_request_max_aggregator_unit
// Stores per-slot votes and groups, answers group maximum queries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A set request
// (cmd 0) does a read-modify-write of the slot memory and holds busy
// through its read and write states; a set that is disabled or names a
// bad group or slot is dropped without going busy. A query (cmd 1) scans
// every slot through the single memory read port, one slot per cycle, and
// strobes its result after the scan; disabled or bad-group queries
// answer in the cycle after acceptance. The result is valid only during the
// single cycle rsp_strobe is high: the receiver cannot stall it. Slot
// active flags clear at reset, so the block is usable right after reset.
// ----------------------------------------------------------------------------
module group_request_max_aggregator_unit
   import grma_pkg::*;
#(
   parameter int NUM_GROUPS     = DEF_NUM_GROUPS,
   parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [REQ_W-1:0]    req_requester,
   input  logic [GRP_W-1:0]    req_group,
   input  logic [VOTE_W-1:0]   req_vote,
   output logic                rsp_strobe,
   output logic [VOTE_W-1:0]   rsp_group_max,
   output logic                rsp_bad_group,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int AW  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
   localparam int SGW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   store_ctl_type     ctl;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [VOTE_W-1:0] wr_vote;
   logic [SGW-1:0]    wr_group;
   logic              rd_active;
   logic [VOTE_W-1:0] rd_vote;
   logic [SGW-1:0]    rd_group;

   grma_ctrl #(
      .NUM_GROUPS     (NUM_GROUPS),
      .NUM_REQUESTERS (NUM_REQUESTERS),
      .AW             (AW),
      .SGW            (SGW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_requester (req_requester),
      .req_group     (req_group),
      .req_vote      (req_vote),
      .rsp_strobe    (rsp_strobe),
      .rsp_group_max (rsp_group_max),
      .rsp_bad_group (rsp_bad_group),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .wr_vote       (wr_vote),
      .wr_group      (wr_group),
      .rd_active     (rd_active),
      .rd_vote       (rd_vote),
      .rd_group      (rd_group)
   );

   grma_store #(
      .NUM_REQUESTERS (NUM_REQUESTERS),
      .AW             (AW),
      .SGW            (SGW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_vote   (wr_vote),
      .wr_group  (wr_group),
      .rd_active (rd_active),
      .rd_vote   (rd_vote),
      .rd_group  (rd_group)
   );

endmodule

// ----- rtl/core/grma_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grma_store
// Per-slot vote and group memory with a registered read port and
// per-slot active flags cleared at reset.
// ----------------------------------------------------------------------------
module grma_store
   import grma_pkg::*;
#(
   parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS,
   parameter int AW             = 5,
   parameter int SGW            = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  store_ctl_type       ctl,
   input  logic [AW-1:0]       rd_addr,
   input  logic [AW-1:0]       wr_addr,
   input  logic [VOTE_W-1:0]   wr_vote,
   input  logic [SGW-1:0]      wr_group,
   output logic                rd_active,
   output logic [VOTE_W-1:0]   rd_vote,
   output logic [SGW-1:0]      rd_group
);

   logic [VOTE_W-1:0] vote_mem [NUM_REQUESTERS];
   logic [SGW-1:0]    grp_mem  [NUM_REQUESTERS];
   logic [NUM_REQUESTERS-1:0] active_ff;

   logic              rd_act_ff;
   logic [VOTE_W-1:0] rd_vote_ff;
   logic [SGW-1:0]    rd_grp_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         vote_mem[wr_addr] <= wr_vote;
         grp_mem[wr_addr]  <= wr_group;
      end
      if (ctl.rd_en) begin
         rd_vote_ff <= vote_mem[rd_addr];
         rd_grp_ff  <= grp_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         rd_act_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            active_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_act_ff <= active_ff[rd_addr];
         end
      end
   end

   // a never-written slot reads as vote 0, group 0
   assign rd_active = rd_act_ff;
   assign rd_vote   = rd_act_ff ? rd_vote_ff : '0;
   assign rd_group  = rd_act_ff ? rd_grp_ff : '0;

endmodule

// ----- rtl/core/grma_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grma_ctrl
// Request sequencer: vote read-modify-write, group scan with running
// maximum, enable register and result strobe.
// ----------------------------------------------------------------------------
module grma_ctrl
   import grma_pkg::*;
#(
   parameter int NUM_GROUPS     = DEF_NUM_GROUPS,
   parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS,
   parameter int AW             = 5,
   parameter int SGW            = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [REQ_W-1:0]    req_requester,
   input  logic [GRP_W-1:0]    req_group,
   input  logic [VOTE_W-1:0]   req_vote,
   output logic                rsp_strobe,
   output logic [VOTE_W-1:0]   rsp_group_max,
   output logic                rsp_bad_group,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output store_ctl_type       ctl,
   output logic [AW-1:0]       rd_addr,
   output logic [AW-1:0]       wr_addr,
   output logic [VOTE_W-1:0]   wr_vote,
   output logic [SGW-1:0]      wr_group,
   input  logic                rd_active,
   input  logic [VOTE_W-1:0]   rd_vote,
   input  logic [SGW-1:0]      rd_group
);

   state_type state_ff, state_in;

   logic              enable_ff;
   logic [REQ_W-1:0]  req_ff;
   logic [GRP_W-1:0]  grp_ff;
   logic [VOTE_W-1:0] vote_ff;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [VOTE_W-1:0] max_ff;
   logic              bad_ff;

   logic accept;
   logic grp_ok;
   logic req_ok;
   logic scan_last;
   logic hit;

   assign accept    = start && !busy;
   assign grp_ok    = 32'(req_group) < NUM_GROUPS;
   assign req_ok    = 32'(req_requester) < NUM_REQUESTERS;
   assign scan_last = cnt_ff == AW'(NUM_REQUESTERS - 1);
   assign hit       = rd_vld_ff && rd_active && (rd_group == SGW'(grp_ff))
                      && (rd_vote > max_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_cmd) == CMD_QUERY) begin
                  state_in = (enable_ff && grp_ok) ? ST_SCAN : ST_RESP;
               end else if (enable_ff && grp_ok && req_ok) begin
                  state_in = ST_SET_RD;
               end
            end
         end
         ST_SET_RD:   state_in = ST_SET_WR;
         ST_SET_WR:   state_in = ST_IDLE;
         ST_SCAN:     state_in = scan_last ? ST_SCAN_END : ST_SCAN;
         ST_SCAN_END: state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      ctl        = '0;
      rd_addr    = AW'(req_ff);
      cnt_in     = cnt_ff;
      rd_vld_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            cnt_in = '0;
         end
         ST_SET_RD: begin
            ctl.rd_en = 1'b1;
         end
         ST_SET_WR: begin
            // repeated vote leaves the slot untouched
            ctl.wr_en = rd_vote != vote_ff;
         end
         ST_SCAN: begin
            ctl.rd_en = 1'b1;
            rd_addr   = cnt_ff;
            rd_vld_in = 1'b1;
            cnt_in    = cnt_ff + AW'(1);
         end
         ST_SCAN_END: begin
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign wr_addr       = AW'(req_ff);
   assign wr_vote       = vote_ff;
   assign wr_group      = SGW'(grp_ff);
   assign rsp_group_max = max_ff;
   assign rsp_bad_group = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         enable_ff <= 1'b1;
         rd_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         cnt_ff    <= cnt_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_requester;
         grp_ff  <= req_group;
         vote_ff <= req_vote;
         max_ff  <= '0;
         bad_ff  <= enable_ff && !grp_ok;
      end else if (hit) begin
         max_ff <= rd_vote;
      end
   end

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en))
      else $error("store read and write in the same cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_type'(req_cmd) == CMD_QUERY) |=> busy)
      else $error("query accepted but sequencer idle");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_group) |-> (rsp_group_max == '0))
      else $error("bad group result with nonzero maximum");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> $past(ctl.rd_en))
      else $error("store write without preceding read");

endmodule

// ----- tb/group_request_max_aggregator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_request_max_aggregator_unit_tb
// Self-checking bench for the group vote maximum unit. A directed sequence
// covers the corner cases. Random vote and query traffic follows, run under
// several enable settings and sender gap rates. Every query answer is
// compared with a shadow copy of the slot store that the bench keeps.
// ----------------------------------------------------------------------------
module group_request_max_aggregator_unit_tb;
   import grma_pkg::*;

   localparam int NGRP = DEF_NUM_GROUPS;
   localparam int NREQ = DEF_NUM_REQUESTERS;
   localparam int SETTLE = NREQ + 8;

   typedef struct {
      logic [VOTE_W-1:0] group_max;
      logic              bad_group;
   } max_answer_type;

   class group_max_tracker;
      logic              enabled;
      logic [VOTE_W-1:0] slot_vote [NREQ];
      logic [2:0]        slot_group[NREQ];
      logic              slot_active[NREQ];
      max_answer_type    answers_due[$];
      int                mismatches;
      int                checked;

      function new();
         enabled = 1'b1;
         for (int i = 0; i < NREQ; i++) begin
            slot_vote[i]   = '0;
            slot_group[i]  = '0;
            slot_active[i] = 1'b0;
         end
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_enable(logic v);
         enabled = v;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      // a query pushes its answer, a vote updates the shadow store
      function void note_request(cmd_type c, logic [REQ_W-1:0] r, logic [GRP_W-1:0] g,
                                 logic [VOTE_W-1:0] v);
         max_answer_type a;
         a.group_max = '0;
         a.bad_group = 1'b0;
         if (c == CMD_QUERY) begin
            if (enabled) begin
               if (g >= NGRP) begin
                  a.bad_group = 1'b1;
               end else begin
                  for (int i = 0; i < NREQ; i++) begin
                     if (slot_active[i] && slot_group[i] == g && slot_vote[i] > a.group_max)
                        a.group_max = slot_vote[i];
                  end
               end
            end
            answers_due.push_back(a);
         end else if (enabled && g < NGRP && r < NREQ && slot_vote[r] != v) begin
            slot_active[r] = 1'b1;
            slot_vote[r]   = v;
            slot_group[r]  = g[2:0];
         end
      endfunction

      function void check_result(logic [VOTE_W-1:0] gm, logic bg);
         max_answer_type a;
         checked++;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result group_max=%0d bad_group=%0d", $realtime, gm, bg);
            return;
         end
         a = answers_due.pop_front();
         if (gm !== a.group_max || bg !== a.bad_group) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch group_max exp %0d got %0d, bad_group exp %0d got %0d",
                        $realtime, a.group_max, gm, a.bad_group, bg);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd;
   logic [REQ_W-1:0]  req_requester;
   logic [GRP_W-1:0]  req_group;
   logic [VOTE_W-1:0] req_vote;
   logic              rsp_strobe;
   logic [VOTE_W-1:0] rsp_group_max;
   logic              rsp_bad_group;
   logic              csr_wr_en;
   logic              csr_wr_data;

   group_max_tracker tracker;
   int               sent_count;
   int               idle_pct;

   group_request_max_aggregator_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_requester (req_requester),
      .req_group     (req_group),
      .req_vote      (req_vote),
      .rsp_strobe    (rsp_strobe),
      .rsp_group_max (rsp_group_max),
      .rsp_bad_group (rsp_bad_group),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_result(rsp_group_max, rsp_bad_group);
   end

   // start stays high across back-to-back requests, lowered only for a gap
   task automatic send_request(cmd_type c, logic [REQ_W-1:0] r, logic [GRP_W-1:0] g,
                               logic [VOTE_W-1:0] v);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(NREQ + 8, 1) : $urandom_range(6, 1);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      start         <= 1'b1;
      req_cmd       <= c;
      req_requester <= r;
      req_group     <= g;
      req_vote      <= v;
      do @(posedge clock); while (busy);
      tracker.note_request(c, r, g, v);
      sent_count++;
   endtask

   // block is idle once every answer is in and the SETTLE wait has passed
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_enable(logic v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      tracker.set_enable(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_traffic(int count);
      cmd_type           c;
      logic [REQ_W-1:0]  r;
      logic [GRP_W-1:0]  g;
      logic [VOTE_W-1:0] v;
      int                pick;
      for (int i = 0; i < count; i++) begin
         c = ($urandom_range(99) < 40) ? CMD_QUERY : CMD_SET;
         r = REQ_W'($urandom_range(NREQ - 1));
         g = ($urandom_range(99) < 85) ? GRP_W'($urandom_range(NGRP - 1))
                                       : GRP_W'($urandom_range(15));
         pick = $urandom_range(99);
         if (pick < 15)
            v = tracker.slot_vote[r];
         else if (pick < 20)
            v = '0;
         else if (pick < 25)
            v = '1;
         else
            v = VOTE_W'($urandom_range(255));
         send_request(c, r, g, v);
      end
   endtask

   initial begin
      tracker       = new();
      sent_count    = 0;
      idle_pct      = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = CMD_SET;
      req_requester = '0;
      req_group     = '0;
      req_vote      = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, then a bad group
      send_request(CMD_QUERY, 5'd0, 4'd0, 8'd0);
      send_request(CMD_QUERY, 5'd31, 4'd15, 8'd255);
      // first vote of zero repeats the cleared value and must not activate
      send_request(CMD_SET, 5'd0, 4'd0, 8'd0);
      send_request(CMD_QUERY, 5'd0, 4'd0, 8'd0);
      send_request(CMD_SET, 5'd31, 4'd7, 8'd255);
      send_request(CMD_QUERY, 5'd0, 4'd7, 8'd0);
      // vote with a bad group is dropped
      send_request(CMD_SET, 5'd5, 4'd8, 8'd10);
      send_request(CMD_QUERY, 5'd5, 4'd8, 8'd0);
      // repeated value keeps the slot in its old group
      send_request(CMD_SET, 5'd31, 4'd0, 8'd255);
      send_request(CMD_QUERY, 5'd0, 4'd7, 8'd0);
      send_request(CMD_SET, 5'd31, 4'd0, 8'd1);
      send_request(CMD_QUERY, 5'd0, 4'd0, 8'd0);
      send_request(CMD_QUERY, 5'd0, 4'd7, 8'd0);
      send_request(CMD_SET, 5'd2, 4'd3, 8'd200);
      send_request(CMD_SET, 5'd3, 4'd3, 8'd100);
      send_request(CMD_QUERY, 5'd0, 4'd3, 8'd0);
      send_request(CMD_SET, 5'd2, 4'd3, 8'd0);
      send_request(CMD_QUERY, 5'd0, 4'd3, 8'd0);

      write_enable(1'b0);
      send_request(CMD_QUERY, 5'd0, 4'd3, 8'd0);
      send_request(CMD_QUERY, 5'd0, 4'd12, 8'd0);
      send_request(CMD_SET, 5'd4, 4'd3, 8'd250);
      write_enable(1'b1);
      send_request(CMD_QUERY, 5'd0, 4'd3, 8'd0);
      send_request(CMD_QUERY, 5'd0, 4'd9, 8'd0);

      idle_pct = 0;
      random_traffic(120);
      idle_pct = 50;
      random_traffic(120);
      write_enable(1'b0);
      idle_pct = 0;
      random_traffic(40);
      write_enable(1'b1);
      idle_pct = 29;
      random_traffic(120);
      idle_pct = 50;
      random_traffic(100);

      wait_idle();
      $display("sent %0d requests over enable on/off and gap rates of 0, 29 and 50 percent",
               sent_count);
      $display("checked %0d query results, %0d mismatches", tracker.checked,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
